FILE: hw/rtl/asbc_pkg.sv
// ----------------------------------------------------------------------------
// asbc_pkg
// Shared constants, types and helpers of the additive sprite blend clip unit.
// ----------------------------------------------------------------------------
package asbc_pkg;

    localparam int MAX_SIDE_DEF = 4096;  // Largest image or screen side.
    localparam int SIZE_W       = 13;    // Width of the size registers.
    localparam int CENTER_W     = 14;    // Width of the center registers.
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 14;
    localparam int CHAN_W       = 8;
    localparam int INDEX_W      = 24;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam logic [SIZE_W-1:0]   SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SIZE_W-1:0]   SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [CENTER_W-1:0] CENTER_X_RST      = 14'd512;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST      = 14'd384;
    localparam logic [SIZE_W-1:0]   IMAGE_WIDTH_RST   = 13'd256;
    localparam logic [SIZE_W-1:0]   IMAGE_HEIGHT_RST  = 13'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 3'd0,
        CFG_SCREEN_HEIGHT = 3'd1,
        CFG_CENTER_X      = 3'd2,
        CFG_CENTER_Y      = 3'd3,
        CFG_IMAGE_WIDTH   = 3'd4,
        CFG_IMAGE_HEIGHT  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } t_rgb;

    // Channel sum that sticks at full scale instead of wrapping.
    function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
        logic [CHAN_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/asbc_cfg.sv
// ----------------------------------------------------------------------------
// asbc_cfg
// Geometry registers with write port; presents sizes clamped to the legal range.
// ----------------------------------------------------------------------------
module asbc_cfg #(
    parameter int  MAX_SIDE = asbc_pkg::MAX_SIDE_DEF,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1)
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [asbc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [asbc_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output logic [SIDE_W-1:0]                       o_screen_w,
    output logic [SIDE_W-1:0]                       o_screen_h,
    output logic [SIDE_W-1:0]                       o_image_w,
    output logic [SIDE_W-1:0]                       o_image_h,
    output logic signed [asbc_pkg::CENTER_W-1:0]    o_center_x,
    output logic signed [asbc_pkg::CENTER_W-1:0]    o_center_y
);

    logic [asbc_pkg::SIZE_W-1:0]   r_screen_w;
    logic [asbc_pkg::SIZE_W-1:0]   r_screen_h;
    logic [asbc_pkg::CENTER_W-1:0] r_center_x;
    logic [asbc_pkg::CENTER_W-1:0] r_center_y;
    logic [asbc_pkg::SIZE_W-1:0]   r_image_w;
    logic [asbc_pkg::SIZE_W-1:0]   r_image_h;

    // Limits a size to MAX_SIDE; image sizes of zero are taken as one.
    function automatic logic [SIDE_W-1:0] clamp_side(
        input logic [asbc_pkg::SIZE_W-1:0] v,
        input logic                        zero_is_one
    );
        logic [SIDE_W-1:0] res;
        if (32'(v) > 32'(MAX_SIDE)) begin
            res = SIDE_W'(MAX_SIDE);
        end else if (zero_is_one && (v == '0)) begin
            res = SIDE_W'(1);
        end else begin
            res = SIDE_W'(v);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= asbc_pkg::SCREEN_WIDTH_RST;
            r_screen_h <= asbc_pkg::SCREEN_HEIGHT_RST;
            r_center_x <= asbc_pkg::CENTER_X_RST;
            r_center_y <= asbc_pkg::CENTER_Y_RST;
            r_image_w  <= asbc_pkg::IMAGE_WIDTH_RST;
            r_image_h  <= asbc_pkg::IMAGE_HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (asbc_pkg::t_cfg_idx'(i_cfg_index))
                asbc_pkg::CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data[asbc_pkg::SIZE_W-1:0];
                asbc_pkg::CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data[asbc_pkg::SIZE_W-1:0];
                asbc_pkg::CFG_CENTER_X:      r_center_x <= i_cfg_data;
                asbc_pkg::CFG_CENTER_Y:      r_center_y <= i_cfg_data;
                asbc_pkg::CFG_IMAGE_WIDTH:   r_image_w  <= i_cfg_data[asbc_pkg::SIZE_W-1:0];
                asbc_pkg::CFG_IMAGE_HEIGHT:  r_image_h  <= i_cfg_data[asbc_pkg::SIZE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_screen_w = clamp_side(r_screen_w, 1'b0);
    assign o_screen_h = clamp_side(r_screen_h, 1'b0);
    assign o_image_w  = clamp_side(r_image_w, 1'b1);
    assign o_image_h  = clamp_side(r_image_h, 1'b1);
    assign o_center_x = $signed(r_center_x);
    assign o_center_y = $signed(r_center_y);

endmodule

FILE: hw/rtl/asbc_pos.sv
// ----------------------------------------------------------------------------
// asbc_pos
// Input register stage: raster counters and target screen coordinates.
// ----------------------------------------------------------------------------
module asbc_pos #(
    parameter int  MAX_SIDE = asbc_pkg::MAX_SIDE_DEF,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1),
    localparam int CNT_W    = $clog2(MAX_SIDE),
    localparam int POS_W    = ((asbc_pkg::CENTER_W > CNT_W + 1) ?
                               asbc_pkg::CENTER_W : CNT_W + 1) + 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  asbc_pkg::t_rgb                       i_image,
    input  asbc_pkg::t_rgb                       i_screen,
    input  logic                                 i_advance,
    input  logic [SIDE_W-1:0]                    i_image_w,
    input  logic [SIDE_W-1:0]                    i_image_h,
    input  logic signed [asbc_pkg::CENTER_W-1:0] i_center_x,
    input  logic signed [asbc_pkg::CENTER_W-1:0] i_center_y,
    output logic                                 o_valid,
    output logic signed [POS_W-1:0]              o_tx,
    output logic signed [POS_W-1:0]              o_ty,
    output asbc_pkg::t_rgb                       o_image,
    output asbc_pkg::t_rgb                       o_screen,
    output logic                                 o_last
);

    logic                    r_valid;
    logic [CNT_W-1:0]        r_col;
    logic [CNT_W-1:0]        r_row;
    logic signed [POS_W-1:0] r_tx;
    logic signed [POS_W-1:0] r_ty;
    asbc_pkg::t_rgb          r_image;
    asbc_pkg::t_rgb          r_screen;
    logic                    r_last;

    logic                    n_valid;
    logic [CNT_W-1:0]        n_col;
    logic [CNT_W-1:0]        n_row;
    logic signed [POS_W-1:0] n_tx;
    logic signed [POS_W-1:0] n_ty;
    logic                    take;
    logic                    end_row;
    logic                    end_img;

    assign o_stall = r_valid && !i_advance;
    assign take    = i_valid && !o_stall;

    assign end_row = (32'(r_col) + 32'd1) >= 32'(i_image_w);
    assign end_img = end_row && ((32'(r_row) + 32'd1) >= 32'(i_image_h));

    // Top-left corner sits at center minus half the size, rounded down.
    assign n_tx = POS_W'(i_center_x) - POS_W'(i_image_w >> 1) + POS_W'(r_col);
    assign n_ty = POS_W'(i_center_y) - POS_W'(i_image_h >> 1) + POS_W'(r_row);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (take) begin
            priority if (end_img) begin
                n_col = '0;
                n_row = '0;
            end else if (end_row) begin
                n_col = '0;
                n_row = r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_comb begin
        priority if (take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_valid <= n_valid;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_image  <= i_image;
            r_screen <= i_screen;
            r_last   <= end_img;
        end
    end

    assign o_valid  = r_valid;
    assign o_tx     = r_tx;
    assign o_ty     = r_ty;
    assign o_image  = r_image;
    assign o_screen = r_screen;
    assign o_last   = r_last;

endmodule

FILE: hw/rtl/asbc_blend.sv
// ----------------------------------------------------------------------------
// asbc_blend
// Result register stage: clipping, pixel index and saturating channel adds.
// ----------------------------------------------------------------------------
module asbc_blend #(
    parameter int  MAX_SIDE = asbc_pkg::MAX_SIDE_DEF,
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1),
    localparam int CNT_W    = $clog2(MAX_SIDE),
    localparam int POS_W    = ((asbc_pkg::CENTER_W > CNT_W + 1) ?
                               asbc_pkg::CENTER_W : CNT_W + 1) + 2,
    localparam int PROD_W   = CNT_W + SIDE_W + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_advance,
    input  logic signed [POS_W-1:0]          i_tx,
    input  logic signed [POS_W-1:0]          i_ty,
    input  asbc_pkg::t_rgb                   i_image,
    input  asbc_pkg::t_rgb                   i_screen,
    input  logic                             i_last,
    input  logic [SIDE_W-1:0]                i_screen_w,
    input  logic [SIDE_W-1:0]                i_screen_h,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic                             o_write_enable,
    output logic [asbc_pkg::INDEX_W-1:0]     o_pixel_index,
    output asbc_pkg::t_rgb                   o_rgb,
    output logic                             o_last
);

    logic                         r_valid;
    logic                         r_write_enable;
    logic [asbc_pkg::INDEX_W-1:0] r_pixel_index;
    asbc_pkg::t_rgb               r_rgb;
    logic                         r_last;

    logic                         in_bounds;
    logic [PROD_W-1:0]            index_full;
    logic [asbc_pkg::INDEX_W-1:0] n_pixel_index;
    asbc_pkg::t_rgb               n_rgb;

    assign o_advance = !r_valid || !i_stall;

    assign in_bounds = !i_tx[POS_W-1] && !i_ty[POS_W-1] &&
                       (32'($unsigned(i_tx)) < 32'(i_screen_w)) &&
                       (32'($unsigned(i_ty)) < 32'(i_screen_h));

    // Inside the screen both coordinates are below MAX_SIDE, so the low
    // counter-width bits carry them completely.
    assign index_full = PROD_W'(i_ty[CNT_W-1:0]) * PROD_W'(i_screen_w) +
                        PROD_W'(i_tx[CNT_W-1:0]);

    always_comb begin
        if (in_bounds) begin
            n_pixel_index = asbc_pkg::INDEX_W'(index_full);
            n_rgb.blue    = asbc_pkg::sat_add(i_screen.blue, i_image.blue);
            n_rgb.green   = asbc_pkg::sat_add(i_screen.green, i_image.green);
            n_rgb.red     = asbc_pkg::sat_add(i_screen.red, i_image.red);
        end else begin
            n_pixel_index = '0;
            n_rgb         = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_valid) begin
            r_write_enable <= in_bounds;
            r_pixel_index  <= n_pixel_index;
            r_rgb          <= n_rgb;
            r_last         <= i_last;
        end
    end

    assign o_valid        = r_valid;
    assign o_write_enable = r_write_enable;
    assign o_pixel_index  = r_pixel_index;
    assign o_rgb          = r_rgb;
    assign o_last         = r_last;

endmodule

FILE: hw/rtl/additive_sprite_blend_clip_unit.sv
// ----------------------------------------------------------------------------
// additive_sprite_blend_clip_unit
// Additive glow blit with screen clipping, one raster pixel per word.
// ----------------------------------------------------------------------------
// An accepted input word passes through the input register and then the result register to its result word.
// Throughput: one word per cycle while the receiver does not stall, set by the two-register pipeline.
// The input register and the result register each advance when the stage
// after them is empty or is being drained, so stalls cost no bubbles.
// Reset (synchronous, active low) empties the pipeline, clears the raster
// counters and loads the geometry registers with their default values.
// ----------------------------------------------------------------------------
module additive_sprite_blend_clip_unit #(
    parameter int MAX_SIDE = asbc_pkg::MAX_SIDE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [asbc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [asbc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // Input pixel channel.
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [asbc_pkg::CHAN_W-1:0]         i_image_blue,
    input  logic [asbc_pkg::CHAN_W-1:0]         i_image_green,
    input  logic [asbc_pkg::CHAN_W-1:0]         i_image_red,
    input  logic [asbc_pkg::CHAN_W-1:0]         i_screen_blue,
    input  logic [asbc_pkg::CHAN_W-1:0]         i_screen_green,
    input  logic [asbc_pkg::CHAN_W-1:0]         i_screen_red,
    // Result channel.
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_write_enable,
    output logic [asbc_pkg::INDEX_W-1:0]        o_pixel_index,
    output logic [asbc_pkg::CHAN_W-1:0]         o_out_blue,
    output logic [asbc_pkg::CHAN_W-1:0]         o_out_green,
    output logic [asbc_pkg::CHAN_W-1:0]         o_out_red,
    output logic                                o_last_pixel
);

    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CNT_W  = $clog2(MAX_SIDE);
    localparam int POS_W  = ((asbc_pkg::CENTER_W > CNT_W + 1) ?
                             asbc_pkg::CENTER_W : CNT_W + 1) + 2;

    // Clamped geometry. The user must only change it while the pipeline is empty,
    // so that both stages can read it directly; the block does not enforce this.
    logic [SIDE_W-1:0]                    screen_w;
    logic [SIDE_W-1:0]                    screen_h;
    logic [SIDE_W-1:0]                    image_w;
    logic [SIDE_W-1:0]                    image_h;
    logic signed [asbc_pkg::CENTER_W-1:0] center_x;
    logic signed [asbc_pkg::CENTER_W-1:0] center_y;

    asbc_pkg::t_rgb          in_image;
    asbc_pkg::t_rgb          in_screen;
    asbc_pkg::t_rgb          pos_image;
    asbc_pkg::t_rgb          pos_screen;
    asbc_pkg::t_rgb          out_rgb;
    logic                    pos_valid;
    logic signed [POS_W-1:0] pos_tx;
    logic signed [POS_W-1:0] pos_ty;
    logic                    pos_last;
    logic                    blend_advance;

    assign in_image.blue   = i_image_blue;
    assign in_image.green  = i_image_green;
    assign in_image.red    = i_image_red;
    assign in_screen.blue  = i_screen_blue;
    assign in_screen.green = i_screen_green;
    assign in_screen.red   = i_screen_red;

    asbc_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_screen_w  (screen_w),
        .o_screen_h  (screen_h),
        .o_image_w   (image_w),
        .o_image_h   (image_h),
        .o_center_x  (center_x),
        .o_center_y  (center_y)
    );

    // First stage: walks the image in raster order and works out where the
    // current pixel lands on the screen.
    asbc_pos #(
        .MAX_SIDE (MAX_SIDE)
    ) u_pos (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_image    (in_image),
        .i_screen   (in_screen),
        .i_advance  (blend_advance),
        .i_image_w  (image_w),
        .i_image_h  (image_h),
        .i_center_x (center_x),
        .i_center_y (center_y),
        .o_valid    (pos_valid),
        .o_tx       (pos_tx),
        .o_ty       (pos_ty),
        .o_image    (pos_image),
        .o_screen   (pos_screen),
        .o_last     (pos_last)
    );

    // Second stage: clips against the screen, forms the linear pixel index
    // and adds the glow onto the screen color with saturation.
    asbc_blend #(
        .MAX_SIDE (MAX_SIDE)
    ) u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (pos_valid),
        .o_advance      (blend_advance),
        .i_tx           (pos_tx),
        .i_ty           (pos_ty),
        .i_image        (pos_image),
        .i_screen       (pos_screen),
        .i_last         (pos_last),
        .i_screen_w     (screen_w),
        .i_screen_h     (screen_h),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_write_enable (o_write_enable),
        .o_pixel_index  (o_pixel_index),
        .o_rgb          (out_rgb),
        .o_last         (o_last_pixel)
    );

    assign o_out_blue  = out_rgb.blue;
    assign o_out_green = out_rgb.green;
    assign o_out_red   = out_rgb.red;

endmodule

FILE: hw/rtl/asbc_checker.sv
// ----------------------------------------------------------------------------
// asbc_checker
// Port-level checks of the additive sprite blend clip unit, bound to the top.
// ----------------------------------------------------------------------------
module asbc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic                            o_write_enable,
    input logic [asbc_pkg::INDEX_W-1:0]    o_pixel_index,
    input logic [asbc_pkg::CHAN_W-1:0]     o_out_blue,
    input logic [asbc_pkg::CHAN_W-1:0]     o_out_green,
    input logic [asbc_pkg::CHAN_W-1:0]     o_out_red,
    input logic                            o_last_pixel
);

    // Reset empties the pipeline.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // With no result waiting, the input side must be open.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled while result register is empty");

    // A clipped pixel carries a zero index and zero color.
    a_clip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_write_enable) |->
            (o_pixel_index == '0) && (o_out_blue == '0) &&
            (o_out_green == '0) && (o_out_red == '0))
        else $error("clipped result with nonzero payload");

    // A stalled result is held unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            o_valid && $stable(o_pixel_index) && $stable(o_write_enable) &&
            $stable(o_out_blue) && $stable(o_out_green) &&
            $stable(o_out_red) && $stable(o_last_pixel))
        else $error("stalled result changed");

endmodule

bind additive_sprite_blend_clip_unit asbc_checker u_asbc_checker (.*);

FILE: bench/tb_additive_sprite_blend_clip_unit.sv
// ----------------------------------------------------------------------------
// tb_additive_sprite_blend_clip_unit
// Self-checking bench for the additive glow blit with screen clipping.
// A shadow copy of the geometry registers and the raster counters predicts
// every result word as its pixel word is accepted. A checker compares each
// result word, field by field, against the oldest prediction. The stimulus
// starts with directed placements: defaults, clipping on all four sides,
// degenerate and oversized sizes, and writes to unused register indexes.
// It goes on with a backpressure run and many random geometry phases. Both
// channels idle at random, apart from the backpressure hold and some random phases.
// ----------------------------------------------------------------------------
module tb_additive_sprite_blend_clip_unit;
    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the end of the map. Writes to them must be ignored.
    localparam logic [asbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [asbc_pkg::CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int PIPE_LATENCY   = 2;
    localparam int END_WAIT       = 4 * PIPE_LATENCY;
    localparam int RX_HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PIXELS  = 500;

    // One input word: the glow pixel and the screen pixel under it.
    typedef struct packed {
        asbc_pkg::t_rgb image;
        asbc_pkg::t_rgb screen;
    } t_glow_pixel;

    // One result word as the block should present it.
    typedef struct packed {
        logic                         write_enable;
        logic [asbc_pkg::INDEX_W-1:0] pixel_index;
        asbc_pkg::t_rgb               color;
        logic                         last_pixel;
    } t_blend_word;

    // Every input of the block starts at a known value.
    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_cfg_we       = 1'b0;
    logic [asbc_pkg::CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [asbc_pkg::CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                            i_valid        = 1'b0;
    logic [asbc_pkg::CHAN_W-1:0]     i_image_blue   = '0;
    logic [asbc_pkg::CHAN_W-1:0]     i_image_green  = '0;
    logic [asbc_pkg::CHAN_W-1:0]     i_image_red    = '0;
    logic [asbc_pkg::CHAN_W-1:0]     i_screen_blue  = '0;
    logic [asbc_pkg::CHAN_W-1:0]     i_screen_green = '0;
    logic [asbc_pkg::CHAN_W-1:0]     i_screen_red   = '0;
    logic                            i_stall        = 1'b0;

    logic                            o_stall;
    logic                            o_valid;
    logic                            o_write_enable;
    logic [asbc_pkg::INDEX_W-1:0]    o_pixel_index;
    logic [asbc_pkg::CHAN_W-1:0]     o_out_blue;
    logic [asbc_pkg::CHAN_W-1:0]     o_out_green;
    logic [asbc_pkg::CHAN_W-1:0]     o_out_red;
    logic                            o_last_pixel;

    additive_sprite_blend_clip_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_image_blue   (i_image_blue),
        .i_image_green  (i_image_green),
        .i_image_red    (i_image_red),
        .i_screen_blue  (i_screen_blue),
        .i_screen_green (i_screen_green),
        .i_screen_red   (i_screen_red),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_write_enable (o_write_enable),
        .o_pixel_index  (o_pixel_index),
        .o_out_blue     (o_out_blue),
        .o_out_green    (o_out_green),
        .o_out_red      (o_out_red),
        .o_last_pixel   (o_last_pixel)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow state of the block, advanced as words are accepted.
    // ------------------------------------------------------------------
    logic [asbc_pkg::SIZE_W-1:0]   screen_w_q = asbc_pkg::SCREEN_WIDTH_RST;
    logic [asbc_pkg::SIZE_W-1:0]   screen_h_q = asbc_pkg::SCREEN_HEIGHT_RST;
    logic [asbc_pkg::CENTER_W-1:0] center_x_q = asbc_pkg::CENTER_X_RST;
    logic [asbc_pkg::CENTER_W-1:0] center_y_q = asbc_pkg::CENTER_Y_RST;
    logic [asbc_pkg::SIZE_W-1:0]   image_w_q  = asbc_pkg::IMAGE_WIDTH_RST;
    logic [asbc_pkg::SIZE_W-1:0]   image_h_q  = asbc_pkg::IMAGE_HEIGHT_RST;
    logic [11:0]                   raster_col = '0;
    logic [11:0]                   raster_row = '0;

    t_blend_word pending_blends[$];
    int          mismatch_count = 0;

    // Idling controls shared by the sender and the receiver.
    bit tx_gaps_on    = 1'b1;
    bit rx_idle_on    = 1'b1;
    int rx_hold_token = 0;
    int rx_hold_seen  = 0;
    int rx_stall_left = 0;
    int random_sent   = 0;

    // A size register as the block uses it: raised to a floor and capped.
    function automatic int side_limit(input logic [asbc_pkg::SIZE_W-1:0] v, input int lo);
        int x;
        x = int'(v);
        if (x < lo) return lo;
        if (x > asbc_pkg::MAX_SIDE_DEF) return asbc_pkg::MAX_SIDE_DEF;
        return x;
    endfunction

    function automatic logic [asbc_pkg::CHAN_W-1:0] glow_add(
        input logic [asbc_pkg::CHAN_W-1:0] a,
        input logic [asbc_pkg::CHAN_W-1:0] b
    );
        logic [asbc_pkg::CHAN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, asbc_pkg::CHAN_MAX}) ? asbc_pkg::CHAN_MAX
                                                : s[asbc_pkg::CHAN_W-1:0];
    endfunction

    // Works out the result of one pixel and steps the raster counters.
    function automatic t_blend_word blend_pixel(input t_glow_pixel px);
        int          w, h, sw, sh, left, top, col, row, tx, ty;
        longint      flat;
        bit          on_screen, row_done, image_done;
        t_blend_word r;
        w    = side_limit(image_w_q, 1);
        h    = side_limit(image_h_q, 1);
        sw   = side_limit(screen_w_q, 0);
        sh   = side_limit(screen_h_q, 0);
        left = int'($signed(center_x_q)) - w / 2;
        top  = int'($signed(center_y_q)) - h / 2;
        col  = int'(raster_col);
        row  = int'(raster_row);
        tx   = left + col;
        ty   = top + row;
        on_screen = (tx >= 0) && (ty >= 0) && (tx < sw) && (ty < sh);
        r = '0;
        r.write_enable = on_screen;
        if (on_screen) begin
            flat = longint'(ty) * longint'(sw) + longint'(tx);
            r.pixel_index = flat[asbc_pkg::INDEX_W-1:0];
            r.color.blue  = glow_add(px.screen.blue, px.image.blue);
            r.color.green = glow_add(px.screen.green, px.image.green);
            r.color.red   = glow_add(px.screen.red, px.image.red);
        end
        // A counter at or past the last column or row also ends the row or
        // image, which matters after the geometry shrank mid-image.
        row_done   = (col + 1 >= w);
        image_done = row_done && (row + 1 >= h);
        r.last_pixel = image_done;
        if (image_done) begin
            raster_col = '0;
            raster_row = '0;
        end else if (row_done) begin
            raster_col = '0;
            raster_row = raster_row + 12'd1;
        end else begin
            raster_col = raster_col + 12'd1;
        end
        return r;
    endfunction

    // Gap lengths: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 90) return int'($urandom_range(1, 3));
        return int'($urandom_range(6, 30));
    endfunction

    function automatic t_glow_pixel random_pixel();
        logic [63:0] raw;
        t_glow_pixel px;
        raw = {$urandom, $urandom};
        px  = raw[$bits(t_glow_pixel)-1:0];
        return px;
    endfunction

    function automatic t_glow_pixel make_pixel(
        input logic [asbc_pkg::CHAN_W-1:0] ib, ig, ir,
        input logic [asbc_pkg::CHAN_W-1:0] sb, sg, sr
    );
        t_glow_pixel px;
        px.image  = '{blue: ib, green: ig, red: ir};
        px.screen = '{blue: sb, green: sg, red: sr};
        return px;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every word taken from the block meets the oldest
    // prediction. Sampling at the edge sees the values from before it.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_blend_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_blends.size() == 0) begin
                $display("%0t ns: result word with nothing expected, index 0x%0h",
                         $time, o_pixel_index);
                mismatch_count++;
            end else begin
                want = pending_blends.pop_front();
                check_field("write_enable", 32'(want.write_enable), 32'(o_write_enable));
                check_field("pixel_index", 32'(want.pixel_index), 32'(o_pixel_index));
                check_field("out_blue", 32'(want.color.blue), 32'(o_out_blue));
                check_field("out_green", 32'(want.color.green), 32'(o_out_green));
                check_field("out_red", 32'(want.color.red), 32'(o_out_red));
                check_field("last_pixel", 32'(want.last_pixel), 32'(o_last_pixel));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold whenever a test bumps
    // the hold token. At most one assignment to i_stall per edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold_seen != rx_hold_token) begin
            rx_hold_seen  <= rx_hold_token;
            rx_stall_left <= RX_HOLD_CYCLES;
            i_stall       <= 1'b1;
        end else if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
            i_stall       <= 1'b1;
            rx_stall_left <= ($urandom_range(0, 9) == 0) ? int'($urandom_range(8, 40))
                                                           : int'($urandom_range(0, 2));
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog: ends the run when nothing has moved for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sender. Valid stays high across back-to-back words; it is only
    // lowered when a gap follows, so it never sees two updates at once.
    // ------------------------------------------------------------------
    task automatic send_pixel(input t_glow_pixel px);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        i_valid        <= 1'b1;
        i_image_blue   <= px.image.blue;
        i_image_green  <= px.image.green;
        i_image_red    <= px.image.red;
        i_screen_blue  <= px.screen.blue;
        i_screen_green <= px.screen.green;
        i_screen_red   <= px.screen.red;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_blends.push_back(blend_pixel(px));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering words and waits until every predicted result came back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_blends.size() != 0) @(posedge i_clk);
    endtask

    // One register write; the enable is left high for a following write.
    task automatic write_reg(input logic [asbc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [asbc_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            asbc_pkg::CFG_SCREEN_WIDTH:  screen_w_q = data[asbc_pkg::SIZE_W-1:0];
            asbc_pkg::CFG_SCREEN_HEIGHT: screen_h_q = data[asbc_pkg::SIZE_W-1:0];
            asbc_pkg::CFG_CENTER_X:      center_x_q = data;
            asbc_pkg::CFG_CENTER_Y:      center_y_q = data;
            asbc_pkg::CFG_IMAGE_WIDTH:   image_w_q  = data[asbc_pkg::SIZE_W-1:0];
            asbc_pkg::CFG_IMAGE_HEIGHT:  image_h_q  = data[asbc_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    // Loads a whole placement once the pipeline has emptied.
    task automatic apply_geometry(input logic [asbc_pkg::CFG_DATA_W-1:0] sw, sh, cx, cy,
                                  iw, ih);
        drain_results();
        write_reg(asbc_pkg::CFG_SCREEN_WIDTH, sw);
        write_reg(asbc_pkg::CFG_SCREEN_HEIGHT, sh);
        write_reg(asbc_pkg::CFG_CENTER_X, cx);
        write_reg(asbc_pkg::CFG_CENTER_Y, cy);
        write_reg(asbc_pkg::CFG_IMAGE_WIDTH, iw);
        write_reg(asbc_pkg::CFG_IMAGE_HEIGHT, ih);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Reset placement lies well inside the default screen. Channel sums at
    // zero, with both inputs at full scale, exactly at the limit and just over it.
    task automatic test_default_geometry();
        send_pixel(make_pixel(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
        send_pixel(make_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_pixel(make_pixel(8'h80, 8'h7F, 8'h01, 8'h80, 8'h80, 8'hFE));
    endtask

    // A 3x2 image hanging off the top-left corner, then off the bottom-right
    // corner of an 8x6 screen. The first word after the change still sits
    // past the last column of the shrunken image and ends its row.
    task automatic test_edge_clipping();
        apply_geometry(14'd8, 14'd6, 14'd0, 14'd0, 14'd3, 14'd2);
        repeat (7) send_pixel(random_pixel());
        apply_geometry(14'd8, 14'd6, 14'd8, 14'd6, 14'd3, 14'd2);
        repeat (6) send_pixel(random_pixel());
    endtask

    // A zero image size acts as one; a zero screen side clips everything.
    task automatic test_degenerate_sizes();
        apply_geometry(14'd0, 14'd10, 14'd0, 14'd0, 14'd0, 14'd0);
        send_pixel(random_pixel());
        apply_geometry(14'd10, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
        send_pixel(random_pixel());
        apply_geometry(14'd10, 14'd10, 14'd0, 14'd0, 14'd0, 14'd0);
        send_pixel(random_pixel());
    endtask

    // Sizes above the cap, the top pixel index and both center extremes.
    task automatic test_oversized_geometry();
        apply_geometry(14'h3FFF, 14'h3FFF, 14'h1FFF, 14'h1FFF, 14'h3FFF, 14'h3FFF);
        send_pixel(random_pixel());
        apply_geometry(14'h1000, 14'h1000, 14'd4095, 14'd4095, 14'd1, 14'd1);
        send_pixel(make_pixel(8'hFF, 8'h00, 8'hAA, 8'h01, 8'hFF, 8'h55));
        apply_geometry(14'h1000, 14'h1000, 14'h2000, 14'h2000, 14'd1, 14'd1);
        send_pixel(random_pixel());
    endtask

    // Writes beyond the register map must leave the placement alone.
    task automatic test_unused_register_index();
        drain_results();
        write_reg(CFG_SPARE_6, asbc_pkg::CFG_DATA_W'($urandom));
        write_reg(CFG_SPARE_7, asbc_pkg::CFG_DATA_W'($urandom));
        i_cfg_we <= 1'b0;
        send_pixel(random_pixel());
    endtask

    // The receiver holds off for a long stretch while words keep coming,
    // so the block fills and stalls its input. Then the sender pauses until
    // every result is back and resumes with random idling.
    task automatic test_backpressure();
        apply_geometry(14'd16, 14'd16, 14'd8, 14'd8, 14'd4, 14'd4);
        tx_gaps_on = 1'b0;
        rx_idle_on = 1'b0;
        rx_hold_token++;
        repeat (24) send_pixel(random_pixel());
        drain_results();
        tx_gaps_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (16) send_pixel(random_pixel());
    endtask

    // Random placements, mostly small so that whole images go by, some
    // near the size cap and some with every register bit random.
    task automatic test_random_geometry();
        int kind, sw, sh, iw, ih, cx, cy, n;
        while (random_sent < RANDOM_PIXELS) begin
            kind = int'($urandom_range(0, 7));
            if (kind == 0) begin
                apply_geometry(asbc_pkg::CFG_DATA_W'($urandom),
                               asbc_pkg::CFG_DATA_W'($urandom),
                               asbc_pkg::CFG_DATA_W'($urandom),
                               asbc_pkg::CFG_DATA_W'($urandom),
                               asbc_pkg::CFG_DATA_W'($urandom),
                               asbc_pkg::CFG_DATA_W'($urandom));
                n = int'($urandom_range(4, 20));
            end else if (kind == 1) begin
                sw = int'($urandom_range(4000, 4096));
                sh = int'($urandom_range(4000, 4096));
                iw = int'($urandom_range(4090, 4096));
                ih = int'($urandom_range(1, 3));
                cx = int'($urandom_range(0, sw + 2048)) - 1024;
                cy = int'($urandom_range(0, sh));
                apply_geometry(asbc_pkg::CFG_DATA_W'(sw), asbc_pkg::CFG_DATA_W'(sh),
                               asbc_pkg::CFG_DATA_W'(cx), asbc_pkg::CFG_DATA_W'(cy),
                               asbc_pkg::CFG_DATA_W'(iw), asbc_pkg::CFG_DATA_W'(ih));
                n = int'($urandom_range(4, 20));
            end else begin
                sw = int'($urandom_range(1, 24));
                sh = int'($urandom_range(1, 24));
                iw = int'($urandom_range(0, 8));
                ih = int'($urandom_range(0, 8));
                cx = int'($urandom_range(0, sw + 8)) - 4;
                cy = int'($urandom_range(0, sh + 8)) - 4;
                apply_geometry(asbc_pkg::CFG_DATA_W'(sw), asbc_pkg::CFG_DATA_W'(sh),
                               asbc_pkg::CFG_DATA_W'(cx), asbc_pkg::CFG_DATA_W'(cy),
                               asbc_pkg::CFG_DATA_W'(iw), asbc_pkg::CFG_DATA_W'(ih));
                n = (iw > 0 ? iw : 1) * (ih > 0 ? ih : 1) + 4;
                n = int'($urandom_range(1, (n < 60) ? n : 60));
            end
            tx_gaps_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            repeat (n) begin
                send_pixel(random_pixel());
                random_sent++;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_geometry();
        test_edge_clipping();
        test_degenerate_sizes();
        test_oversized_geometry();
        test_unused_register_index();
        test_backpressure();
        test_random_geometry();

        // Let the last words out, then watch a little longer for strays.
        drain_results();
        repeat (END_WAIT) @(posedge i_clk);
        if (pending_blends.size() != 0) begin
            $display("%0t ns: %0d results never arrived", $time, pending_blends.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/asbc_pkg.sv
hw/rtl/asbc_cfg.sv
hw/rtl/asbc_pos.sv
hw/rtl/asbc_blend.sv
hw/rtl/additive_sprite_blend_clip_unit.sv
hw/rtl/asbc_checker.sv
bench/tb_additive_sprite_blend_clip_unit.sv
